FILE: rtl/ilsc_pkg.sv
// Shared types and constants for the infusion line state classifier.
package ilsc_pkg;

   localparam int unsigned DIVIDEND_W = 28;
   localparam int unsigned DIVISOR_W  = 24;
   localparam int unsigned CSR_ADDR_W = 5;

   typedef enum logic [2:0] {
      LS_OK        = 3'd0,
      LS_LOW       = 3'd1,
      LS_OCCLUSION = 3'd2,
      LS_FREE_FLOW = 3'd3,
      LS_MISMATCH  = 3'd4,
      LS_EMPTY     = 3'd5
   } line_state_type;

   typedef enum logic [2:0] {
      REG_STEADY_FRACTION = 3'd0,
      REG_NOISE_FLOOR     = 3'd1,
      REG_RATIO_LOW       = 3'd2,
      REG_RATIO_HIGH      = 3'd3,
      REG_NEARLY_EMPTY    = 3'd4,
      REG_DROP_FACTOR     = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_TREND   = 2'd0,
      OP_RATE    = 2'd1,
      OP_MINUTES = 2'd2
   } div_op_type;

   typedef struct packed {
      logic       load_in;
      logic       div_start;
      div_op_type div_op;
      logic       load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic will_compute;
      logic div_busy;
      logic div_done;
      logic trend_falling;
   } dp_status_type;

endpackage

FILE: rtl/ilsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ilsc_ram #(
   parameter int unsigned WIDTH  = 20,
   parameter int unsigned DEPTH  = 60,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/ilsc_div.sv
// Unsigned restoring divider, two quotient bits per cycle.
module ilsc_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ilsc_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [ilsc_pkg::DIVISOR_W-1:0]    divisor,
   output logic                              busy,
   output logic                              done,
   output logic [ilsc_pkg::DIVIDEND_W-1:0]   quotient
);

   localparam int unsigned STEPS = ilsc_pkg::DIVIDEND_W / 2;
   localparam int unsigned CNT_W = $clog2(STEPS);

   logic [ilsc_pkg::DIVIDEND_W-1:0] q_ff, q_in;
   logic [ilsc_pkg::DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [ilsc_pkg::DIVISOR_W-1:0]  den_ff, den_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;

   logic [ilsc_pkg::DIVISOR_W:0]    t1, t2;
   logic [ilsc_pkg::DIVISOR_W-1:0]  r1, r2;
   logic                            b1, b2;

   always_comb begin
      t1 = {rem_ff, q_ff[ilsc_pkg::DIVIDEND_W-1]};
      b1 = (t1 >= {1'b0, den_ff});
      r1 = b1 ? ilsc_pkg::DIVISOR_W'(t1 - {1'b0, den_ff}) : t1[ilsc_pkg::DIVISOR_W-1:0];
      t2 = {r1, q_ff[ilsc_pkg::DIVIDEND_W-2]};
      b2 = (t2 >= {1'b0, den_ff});
      r2 = b2 ? ilsc_pkg::DIVISOR_W'(t2 - {1'b0, den_ff}) : t2[ilsc_pkg::DIVISOR_W-1:0];

      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = {q_ff[ilsc_pkg::DIVIDEND_W-3:0], b1, b2};
         rem_in = r2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

FILE: rtl/ilsc_dp.sv
// Datapath: registers, weight window, divider, classification and result register.
module ilsc_dp #(
   parameter int unsigned WINDOW_TICKS = 60
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ilsc_pkg::ctrl_cmd_type              cmd,
   output ilsc_pkg::dp_status_type             sts,
   input  logic                                cfg_we,
   input  logic [ilsc_pkg::CSR_ADDR_W-1:0]     cfg_addr,
   input  logic [31:0]                         cfg_wdata,
   output logic [31:0]                         cfg_rdata,
   input  logic                                req_weight_ok,
   input  logic signed [19:0]                  req_weight,
   input  logic                                req_drops_ok,
   input  logic [15:0]                         req_drop_rate,
   input  logic [11:0]                         req_drop_ratio,
   output logic                                rsp_valid_res,
   output logic [2:0]                          rsp_line_state,
   output logic signed [19:0]                  rsp_weight_out,
   output logic signed [23:0]                  rsp_weight_trend,
   output logic signed [16:0]                  rsp_expected_trend,
   output logic                                rsp_steady,
   output logic                                rsp_drops_slow,
   output logic                                rsp_drops_fast,
   output logic [18:0]                         rsp_remaining_volume,
   output logic signed [16:0]                  rsp_minutes_left
);

   localparam int unsigned AW     = $clog2(WINDOW_TICKS);
   localparam int unsigned FILL_W = $clog2(WINDOW_TICKS + 1);
   localparam int unsigned DW     = ilsc_pkg::DIVIDEND_W;
   localparam int unsigned VW     = ilsc_pkg::DIVISOR_W;

   // configuration
   logic [7:0]  sfrac_ff;
   logic [11:0] nfloor12_ff, rlow_ff, rhigh_ff;
   logic [15:0] nempty_ff;
   logic [7:0]  dfactor_ff;
   ilsc_pkg::reg_index_type cfg_idx;

   assign cfg_idx = ilsc_pkg::reg_index_type'(cfg_addr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         sfrac_ff    <= 8'd64;
         nfloor12_ff <= 12'd8;
         rlow_ff     <= 12'd179;
         rhigh_ff    <= 12'd333;
         nempty_ff   <= 16'd320;
         dfactor_ff  <= 8'd20;
      end else if (cfg_we && cfg_addr[1:0] == 2'b00) begin
         unique case (cfg_idx)
            ilsc_pkg::REG_STEADY_FRACTION: sfrac_ff    <= cfg_wdata[7:0];
            ilsc_pkg::REG_NOISE_FLOOR:     nfloor12_ff <= cfg_wdata[11:0];
            ilsc_pkg::REG_RATIO_LOW:       rlow_ff     <= cfg_wdata[11:0];
            ilsc_pkg::REG_RATIO_HIGH:      rhigh_ff    <= cfg_wdata[11:0];
            ilsc_pkg::REG_NEARLY_EMPTY:    nempty_ff   <= cfg_wdata[15:0];
            ilsc_pkg::REG_DROP_FACTOR:     dfactor_ff  <= cfg_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg_rdata = '0;
      if (cfg_addr[1:0] == 2'b00) begin
         unique case (cfg_idx)
            ilsc_pkg::REG_STEADY_FRACTION: cfg_rdata = {24'd0, sfrac_ff};
            ilsc_pkg::REG_NOISE_FLOOR:     cfg_rdata = {20'd0, nfloor12_ff};
            ilsc_pkg::REG_RATIO_LOW:       cfg_rdata = {20'd0, rlow_ff};
            ilsc_pkg::REG_RATIO_HIGH:      cfg_rdata = {20'd0, rhigh_ff};
            ilsc_pkg::REG_NEARLY_EMPTY:    cfg_rdata = {16'd0, nempty_ff};
            ilsc_pkg::REG_DROP_FACTOR:     cfg_rdata = {24'd0, dfactor_ff};
            default:                       cfg_rdata = '0;
         endcase
      end
   end

   // request registers and window bookkeeping
   logic                wok_ff, dok_ff, full_ff;
   logic signed [19:0]  w_ff;
   logic [15:0]         rate_ff;
   logic [11:0]         ratio_ff;
   logic [AW-1:0]       wp_ff, wp_next;
   logic [FILL_W-1:0]   fill_ff, fill_next;
   logic [19:0]         oldest_raw;

   assign wp_next   = (wp_ff == AW'(WINDOW_TICKS - 1)) ? '0 : wp_ff + 1'b1;
   assign fill_next = (fill_ff == FILL_W'(WINDOW_TICKS)) ? fill_ff : fill_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else if (cmd.load_in && req_weight_ok) begin
         wp_ff   <= wp_next;
         fill_ff <= fill_next;
      end
      if (cmd.load_in) begin
         wok_ff   <= req_weight_ok;
         full_ff  <= req_weight_ok && (fill_next == FILL_W'(WINDOW_TICKS));
         w_ff     <= req_weight;
         dok_ff   <= req_drops_ok;
         rate_ff  <= req_drop_rate;
         ratio_ff <= req_drop_ratio;
      end
   end

   // oldest sample sits at the slot after the one being written
   ilsc_ram #(.WIDTH(20), .DEPTH(WINDOW_TICKS)) u_ring (
      .clock (clock),
      .we    (cmd.load_in && req_weight_ok),
      .waddr (wp_ff),
      .wdata (req_weight),
      .raddr (wp_next),
      .rdata (oldest_raw)
   );

   // divider operand selection
   logic signed [20:0] diff;
   logic signed [26:0] prod;
   logic [26:0]        prod_mag;
   logic [7:0]         factor;
   logic signed [23:0] trend_ff, trend_q;
   logic [VW-1:0]      trend_mag;
   logic [15:0]        implied_ff;
   logic signed [16:0] minutes_ff;
   logic               tneg_ff;
   logic [18:0]        remaining;
   logic [DW-1:0]      div_a, quotient;
   logic [VW-1:0]      div_b;
   logic               div_busy, div_done;
   ilsc_pkg::div_op_type op_ff;

   assign diff      = 21'(w_ff) - 21'($signed(oldest_raw));
   assign prod      = 27'(diff) * 27'sd60;
   assign prod_mag  = prod[26] ? 27'(-prod) : prod;
   assign factor    = (dfactor_ff == 8'd0) ? 8'd1 : dfactor_ff;
   assign trend_mag = trend_ff[23] ? VW'(-25'(trend_ff)) : VW'(trend_ff);
   assign remaining = (w_ff > 20'sd0) ? w_ff[18:0] : 19'd0;

   always_comb begin
      unique case (cmd.div_op)
         ilsc_pkg::OP_TREND: begin
            div_a = DW'(prod_mag);
            div_b = VW'(WINDOW_TICKS);
         end
         ilsc_pkg::OP_RATE: begin
            div_a = dok_ff ? DW'(rate_ff) : '0;
            div_b = VW'(factor);
         end
         ilsc_pkg::OP_MINUTES: begin
            div_a = DW'(remaining);
            div_b = trend_mag;
         end
         default: begin
            div_a = '0;
            div_b = VW'(1);
         end
      endcase
   end

   ilsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   // truncated quotient, signed and saturated to 24 bits
   always_comb begin
      if (tneg_ff) begin
         trend_q = (quotient > DW'(8388608)) ? -24'sd8388608 : 24'(-quotient);
      end else begin
         trend_q = (quotient > DW'(8388607)) ? 24'sd8388607 : 24'(quotient);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         op_ff <= cmd.div_op;
         if (cmd.div_op == ilsc_pkg::OP_TREND) begin
            tneg_ff <= prod[26];
         end
      end
      if (cmd.load_in) begin
         minutes_ff <= -17'sd1;
      end else if (div_done) begin
         case (op_ff)
            ilsc_pkg::OP_TREND:   trend_ff   <= trend_q;
            ilsc_pkg::OP_RATE:    implied_ff <= quotient[15:0];
            ilsc_pkg::OP_MINUTES: minutes_ff <= 17'(quotient[15:0]);
            default: ;
         endcase
      end
   end

   assign sts.will_compute  = req_weight_ok && (fill_next == FILL_W'(WINDOW_TICKS));
   assign sts.div_busy      = div_busy;
   assign sts.div_done      = div_done;
   assign sts.trend_falling = (trend_ff < -24'sd8);

   // classification
   logic [31:0]        mag;
   logic [23:0]        lim_frac, lim;
   logic               steady, slow, fast;
   logic [17:0]        limit3;
   logic               below_empty, below_low;
   logic signed [24:0] twice_exp;
   ilsc_pkg::line_state_type state;

   always_comb begin
      mag         = {trend_mag, 8'd0};
      lim_frac    = 24'(sfrac_ff * implied_ff);
      lim         = (lim_frac < {4'd0, nfloor12_ff, 8'd0}) ? {4'd0, nfloor12_ff, 8'd0} : lim_frac;
      steady      = mag < {8'd0, lim};
      slow        = dok_ff && (ratio_ff < rlow_ff);
      fast        = dok_ff && (ratio_ff > rhigh_ff);
      limit3      = 18'(nempty_ff) * 18'd3;
      below_empty = (21'(w_ff) <= $signed({5'd0, nempty_ff}));
      below_low   = (21'(w_ff) <= $signed({3'd0, limit3}));
      twice_exp   = -$signed({8'd0, implied_ff, 1'b0});
      if (below_empty && steady) begin
         state = ilsc_pkg::LS_EMPTY;
      end else if (slow && steady) begin
         state = ilsc_pkg::LS_OCCLUSION;
      end else if (slow) begin
         state = below_low ? ilsc_pkg::LS_LOW : ilsc_pkg::LS_OK;
      end else if (fast && (25'(trend_ff) < twice_exp)) begin
         state = ilsc_pkg::LS_FREE_FLOW;
      end else if (dok_ff && rate_ff > 16'd16 && steady) begin
         state = ilsc_pkg::LS_MISMATCH;
      end else if (below_low) begin
         state = ilsc_pkg::LS_LOW;
      end else begin
         state = ilsc_pkg::LS_OK;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_valid_res        <= full_ff;
         rsp_line_state       <= full_ff ? state : ilsc_pkg::LS_OK;
         rsp_weight_out       <= wok_ff ? w_ff : '0;
         rsp_weight_trend     <= full_ff ? trend_ff : '0;
         rsp_expected_trend   <= full_ff ? -$signed({1'b0, implied_ff}) : '0;
         rsp_steady           <= full_ff && steady;
         rsp_drops_slow       <= full_ff && slow;
         rsp_drops_fast       <= full_ff && fast;
         rsp_remaining_volume <= full_ff ? remaining : '0;
         rsp_minutes_left     <= full_ff ? minutes_ff : -17'sd1;
      end
   end

endmodule

FILE: rtl/ilsc_ctrl.sv
// Controller: sequences window read, up to three divisions and the result hand-off.
module ilsc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ilsc_pkg::ctrl_cmd_type   cmd,
   input  ilsc_pkg::dp_status_type  sts
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_OLD  = 6'b000010,
      S_TDIV = 6'b000100,
      S_RDIV = 6'b001000,
      S_MDIV = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cmd.load_in   = 1'b0;
      cmd.div_start = 1'b0;
      cmd.div_op    = ilsc_pkg::OP_TREND;
      cmd.load_out  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = sts.will_compute ? S_OLD : S_DONE;
            end
         end
         S_OLD: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = ilsc_pkg::OP_TREND;
            state_in      = S_TDIV;
         end
         S_TDIV: begin
            if (sts.div_done) begin
               state_in = S_RDIV;
            end
         end
         S_RDIV: begin
            // rate division starts here once the trend is latched
            if (!sts.div_busy && !sts.div_done) begin
               cmd.div_start = 1'b1;
               cmd.div_op    = ilsc_pkg::OP_RATE;
               state_in      = S_MDIV;
            end
         end
         S_MDIV: begin
            cmd.div_op = ilsc_pkg::OP_MINUTES;
            if (sts.div_done) begin
               state_in = S_DONE;
               if (sts.trend_falling) begin
                  state_in = S_TDIV;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // minutes division follows the rate division when the bag is draining
      if (state_ff == S_MDIV && sts.div_done && sts.trend_falling) begin
         cmd.div_start = 1'b1;
         cmd.div_op    = ilsc_pkg::OP_MINUTES;
         state_in      = S_TDIV;
      end
   end

   // second pass through S_TDIV after the minutes division goes straight out
   logic minutes_run_ff, minutes_run_in;

   always_comb begin
      minutes_run_in = minutes_run_ff;
      if (state_ff == S_IDLE) begin
         minutes_run_in = 1'b0;
      end else if (state_ff == S_MDIV && sts.div_done && sts.trend_falling) begin
         minutes_run_in = 1'b1;
      end
   end

   state_type state_fix;

   always_comb begin
      state_fix = state_in;
      if (state_ff == S_TDIV && sts.div_done && minutes_run_ff) begin
         state_fix = S_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         minutes_run_ff <= 1'b0;
      end else begin
         state_ff       <= state_fix;
         rsp_valid_ff   <= rsp_valid_in;
         minutes_run_ff <= minutes_run_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.div_busy)
      else $error("divider started while busy");
   a_request_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> (state_ff != S_IDLE))
      else $error("accepted request did not start work");
   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result load did not raise valid");
`endif

endmodule

FILE: rtl/infusion_line_state_classifier_top.sv
// Top level of the infusion line state classifier.
// With the weight missing or the window not full, a request goes straight to the result
// hand-off; once full it runs the trend and rate divisions, and the minutes division too
// when the bag is draining. One request at a time, the next taken once the last result is
// handed off and the output is not stalled; the shared divider gives 2 quotient bits/cycle.
// Reset (synchronous, active high): window empty, pointer zero, registers at defaults.
module infusion_line_state_classifier_top #(
   parameter int unsigned WINDOW_TICKS = 60
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_weight_ok,
   input  logic signed [19:0]                  req_weight,
   input  logic                                req_drops_ok,
   input  logic [15:0]                         req_drop_rate,
   input  logic [11:0]                         req_drop_ratio,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_valid_res,
   output logic [2:0]                          rsp_line_state,
   output logic signed [19:0]                  rsp_weight_out,
   output logic signed [23:0]                  rsp_weight_trend,
   output logic signed [16:0]                  rsp_expected_trend,
   output logic                                rsp_steady,
   output logic                                rsp_drops_slow,
   output logic                                rsp_drops_fast,
   output logic [18:0]                         rsp_remaining_volume,
   output logic signed [16:0]                  rsp_minutes_left,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ilsc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   ilsc_pkg::ctrl_cmd_type  cmd;
   ilsc_pkg::dp_status_type sts;

   assign pready = 1'b1;

   ilsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   ilsc_dp #(.WINDOW_TICKS(WINDOW_TICKS)) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .cfg_we               (psel && penable && pwrite),
      .cfg_addr             (paddr),
      .cfg_wdata            (pwdata),
      .cfg_rdata            (prdata),
      .req_weight_ok        (req_weight_ok),
      .req_weight           (req_weight),
      .req_drops_ok         (req_drops_ok),
      .req_drop_rate        (req_drop_rate),
      .req_drop_ratio       (req_drop_ratio),
      .rsp_valid_res        (rsp_valid_res),
      .rsp_line_state       (rsp_line_state),
      .rsp_weight_out       (rsp_weight_out),
      .rsp_weight_trend     (rsp_weight_trend),
      .rsp_expected_trend   (rsp_expected_trend),
      .rsp_steady           (rsp_steady),
      .rsp_drops_slow       (rsp_drops_slow),
      .rsp_drops_fast       (rsp_drops_fast),
      .rsp_remaining_volume (rsp_remaining_volume),
      .rsp_minutes_left     (rsp_minutes_left)
   );

endmodule

FILE: sim/tb_infusion_line_state_classifier_top.sv
// Self-checking testbench for the infusion line state classifier top level.
`timescale 1ns / 100ps

class line_state_scoreboard;
   // expected result fields, oldest first
   bit [119:0] pending[$];
   int         errors;

   // configuration copy
   bit [7:0]  steady_frac;
   bit [11:0] noise_floor;
   bit [11:0] ratio_lo;
   bit [11:0] ratio_hi;
   bit [15:0] empty_level;
   bit [7:0]  drops_per_ml;

   // window copy
   logic signed [19:0] ring[60];
   int fill;
   int wptr;

   function void clear();
      pending.delete();
      fill = 0;
      wptr = 0;
      steady_frac = 64;
      noise_floor = 8;
      ratio_lo = 179;
      ratio_hi = 333;
      empty_level = 320;
      drops_per_ml = 20;
   endfunction

   function void set_reg(ilsc_pkg::reg_index_type idx, bit [31:0] val);
      case (idx)
         ilsc_pkg::REG_STEADY_FRACTION: steady_frac = val[7:0];
         ilsc_pkg::REG_NOISE_FLOOR:     noise_floor = val[11:0];
         ilsc_pkg::REG_RATIO_LOW:       ratio_lo = val[11:0];
         ilsc_pkg::REG_RATIO_HIGH:      ratio_hi = val[11:0];
         ilsc_pkg::REG_NEARLY_EMPTY:    empty_level = val[15:0];
         ilsc_pkg::REG_DROP_FACTOR:     drops_per_ml = val[7:0];
         default: ;
      endcase
   endfunction

   function void note_request(bit wok, logic signed [19:0] w, bit dok, bit [15:0] rate,
                              bit [11:0] ratio);
      longint trend, expd, mins, rem, oldest, lim3, mag, lim, implied, f;
      bit stdy, slow, fast;
      ilsc_pkg::line_state_type st;
      bit [19:0] w_out;
      trend = 0; expd = 0; mins = -1; rem = 0;
      stdy = 0; slow = 0; fast = 0;
      st = ilsc_pkg::LS_OK;
      w_out = 0;
      if (wok) begin
         w_out = w;
         ring[wptr] = w;
         wptr = (wptr + 1) % 60;
         if (fill < 60) fill++;
      end
      if (!wok || fill < 60) begin
         pending.push_back({1'b0, 3'd0, w_out, 24'd0, 17'd0, 3'd0, 19'd0, 17'h1FFFF, 16'd0});
         return;
      end
      oldest = longint'(ring[wptr]);
      lim3 = 3 * longint'(empty_level);
      f = (drops_per_ml == 0) ? 1 : drops_per_ml;
      trend = ((longint'(w) - oldest) * 60) / 60;
      if (trend > 8388607) trend = 8388607;
      if (trend < -8388608) trend = -8388608;
      implied = dok ? rate / f : 0;
      expd = -implied;
      mag = (trend < 0 ? -trend : trend) * 256;
      lim = longint'(steady_frac) * implied;
      if (lim < longint'(noise_floor) * 256) lim = longint'(noise_floor) * 256;
      stdy = mag < lim;
      slow = dok && ratio < ratio_lo;
      fast = dok && ratio > ratio_hi;
      rem = w > 0 ? longint'(w) : 0;
      if (trend < -8) mins = rem / -trend;
      if (w <= longint'(empty_level) && stdy) st = ilsc_pkg::LS_EMPTY;
      else if (slow && stdy) st = ilsc_pkg::LS_OCCLUSION;
      else if (slow) st = (w <= lim3) ? ilsc_pkg::LS_LOW : ilsc_pkg::LS_OK;
      else if (fast && trend < 2 * expd) st = ilsc_pkg::LS_FREE_FLOW;
      else if (dok && rate > 16 && stdy) st = ilsc_pkg::LS_MISMATCH;
      else if (w <= lim3) st = ilsc_pkg::LS_LOW;
      pending.push_back({1'b1, 3'(st), w_out, 24'(trend), 17'(expd), stdy, slow, fast,
                         19'(rem), 17'(mins), 16'd0});
   endfunction

   function void check_result(bit [119:0] got);
      bit [119:0] want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result %h", $time, got);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (want != got) begin
         $display("%0t: mismatch expected %h actual %h", $time, want, got);
         errors++;
      end
   endfunction
endclass

module tb_infusion_line_state_classifier_top;

   logic clock, reset;
   logic req_valid, req_stall, req_weight_ok, req_drops_ok;
   logic signed [19:0] req_weight;
   logic [15:0] req_drop_rate;
   logic [11:0] req_drop_ratio;
   logic rsp_valid, rsp_stall, rsp_valid_res, rsp_steady, rsp_drops_slow, rsp_drops_fast;
   logic [2:0] rsp_line_state;
   logic signed [19:0] rsp_weight_out;
   logic signed [23:0] rsp_weight_trend;
   logic signed [16:0] rsp_expected_trend, rsp_minutes_left;
   logic [18:0] rsp_remaining_volume;
   logic psel, penable, pwrite, pready;
   logic [ilsc_pkg::CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata, prdata;

   line_state_scoreboard sb;
   int sender_idle, receiver_idle;
   logic signed [19:0] bag;

   infusion_line_state_classifier_top dut (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #80ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // receiver: random stall, check on acceptance
   always @(posedge clock) begin
      if (reset) rsp_stall <= 0;
      else begin
         if (rsp_valid && !rsp_stall)
            sb.check_result({rsp_valid_res, rsp_line_state, rsp_weight_out, rsp_weight_trend,
                             rsp_expected_trend, rsp_steady, rsp_drops_slow, rsp_drops_fast,
                             rsp_remaining_volume, rsp_minutes_left, 16'd0});
         rsp_stall <= ($urandom_range(99) < receiver_idle);
      end
   end

   task automatic csr_write(ilsc_pkg::reg_index_type idx, bit [31:0] val);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= ilsc_pkg::CSR_ADDR_W'(4 * idx); pwdata <= val;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      sb.set_reg(idx, val);
      @(posedge clock);
   endtask

   // valid stays up between back-to-back requests; idle cycles and drain drop it
   task automatic send(bit wok, logic signed [19:0] w, bit dok, bit [15:0] rate,
                       bit [11:0] ratio);
      while ($urandom_range(99) < sender_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1; req_weight_ok <= wok; req_weight <= w; req_drops_ok <= dok;
      req_drop_rate <= rate; req_drop_ratio <= ratio;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(wok, w, dok, rate, ratio);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // draining bag: mostly falling weight with occasional random jumps and random sensor content
   task automatic random_ticks(int n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0: bag = 20'($urandom);
            1: bag = 20'(bag - $urandom_range(2000));
            default: bag = 20'(bag - $urandom_range(40));
         endcase
         send($urandom_range(15) != 0, bag, $urandom_range(3) != 0,
              ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1200)),
              ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(120, 400)));
      end
   endtask

   initial begin
      sb = new();
      sb.clear();
      reset = 1; req_valid = 0; req_weight_ok = 0; req_weight = 0; req_drops_ok = 0;
      req_drop_rate = 0; req_drop_ratio = 0; rsp_stall = 0;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      sender_idle = 27; receiver_idle = 79;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: missing weight before fill, field extremes
      send(0, 20'sh7FFFF, 1, 16'hFFFF, 12'hFFF);
      send(1, -20'sd524288, 1, 16'hFFFF, 12'hFFF);
      send(1, 20'sd524287, 0, 0, 0);
      for (int i = 0; i < 57; i++) send(1, 20'sd524287, 1, 16'd400, 12'd256);
      // first full window: zero trend, empty; then big falls give extreme but unsaturated trends (low, free flow, low)
      send(1, -20'sd524288, 1, 16'd0, 12'd0);
      send(0, 0, 1, 16'd20, 12'd100);
      send(1, 20'sd100, 1, 16'd400, 12'd100);
      send(1, 20'sd5000, 1, 16'd65535, 12'd4095);
      send(1, 20'sd900, 1, 16'd17, 12'd256);
      drain();

      bag = 20'sd8000;
      random_ticks(350);
      drain();
      csr_write(ilsc_pkg::REG_STEADY_FRACTION, 255);
      csr_write(ilsc_pkg::REG_NOISE_FLOOR, 0);
      csr_write(ilsc_pkg::REG_RATIO_LOW, 4095);
      csr_write(ilsc_pkg::REG_RATIO_HIGH, 0);
      csr_write(ilsc_pkg::REG_NEARLY_EMPTY, 65535);
      csr_write(ilsc_pkg::REG_DROP_FACTOR, 0);
      random_ticks(350);
      drain();
      sender_idle = 79; receiver_idle = 27;
      csr_write(ilsc_pkg::REG_STEADY_FRACTION, 0);
      csr_write(ilsc_pkg::REG_NOISE_FLOOR, 4095);
      csr_write(ilsc_pkg::REG_RATIO_LOW, 0);
      csr_write(ilsc_pkg::REG_RATIO_HIGH, 4095);
      csr_write(ilsc_pkg::REG_NEARLY_EMPTY, 0);
      csr_write(ilsc_pkg::REG_DROP_FACTOR, 255);
      random_ticks(400);
      drain();
      sender_idle = 0; receiver_idle = 0;
      csr_write(ilsc_pkg::REG_STEADY_FRACTION, 64);
      csr_write(ilsc_pkg::REG_NOISE_FLOOR, 8);
      csr_write(ilsc_pkg::REG_RATIO_LOW, 179);
      csr_write(ilsc_pkg::REG_RATIO_HIGH, 333);
      csr_write(ilsc_pkg::REG_NEARLY_EMPTY, 320);
      csr_write(ilsc_pkg::REG_DROP_FACTOR, 1);
      random_ticks(430);
      drain();

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
